// File: rtl/core/keyword_token_scanner_core_assert.svh
// Assertion macros used by the keyword token scanner checker.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef KEYWORD_TOKEN_SCANNER_CORE_ASSERT_SVH
`define KEYWORD_TOKEN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication
`define KTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyword_token_scanner_core: assertion failed");

// next-cycle implication
`define KTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyword_token_scanner_core: assertion failed");

`endif

// File: rtl/core/kts_pkg.sv
// Package for the keyword token scanner: item types, token codes, keyword tables.
// No dependencies.
`timescale 1ns / 1ps

package kts_pkg;

    typedef enum logic [2:0] {
        TOK_INCLUDE = 3'd0,
        TOK_FN      = 3'd1,
        TOK_END     = 3'd2,
        TOK_ID      = 3'd3,
        TOK_LPAREN  = 3'd4,
        TOK_RPAREN  = 3'd5,
        TOK_STRING  = 3'd6
    } tok_type_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        tok_type_t  token_type;
        logic [7:0] text_start;
        logic [8:0] text_length;
        logic [7:0] body_start;
        logic [8:0] body_length;
        logic       overflow;
        logic       last_in_run;
    } out_item_t;

    // up to two tokens produced by one byte, in emission order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_bundle_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int unsigned NUM_KW = 3;
    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{3'd7, 3'd2, 3'd3};

    localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:7] = '{
        '{"i", "n", "c", "l", "u", "d", "e", 8'h00},
        '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

endpackage

// File: rtl/core/kts_lexer.sv
// Line scanner state and the single-pass token decode for one byte.
// Depends on kts_pkg.
`timescale 1ns / 1ps

module kts_lexer #(
    parameter int unsigned MAX_LINE = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  kts_pkg::in_item_t   item,
    output kts_pkg::res_bundle_t res
);
    import kts_pkg::*;

    localparam int unsigned PW = $clog2(MAX_LINE + 1);

    logic              quote_open_reg, quote_open_next;
    logic [PW-1:0]     line_pos_reg, line_pos_next;
    logic [7:0]        word_start_reg, word_start_next;
    logic [PW-1:0]     word_len_reg, word_len_next;
    logic [7:0]        body_start_reg, body_start_next;
    logic [PW-1:0]     body_len_reg, body_len_next;
    logic [NUM_KW-1:0] kw_flags_reg, kw_flags_next;
    logic              ovf_seen_reg, ovf_seen_next;

    logic              byte_ovf, ovf;
    logic              is_quote, is_lp, is_rp, is_sep;
    logic              do_close, do_open, do_body, do_sep, do_word;
    logic              q_mid, flush, word_tok, par_tok;
    logic [7:0]        ws_mid, bs_mid;
    logic [PW-1:0]     wl_mid, bl_mid;
    logic [NUM_KW-1:0] fl_mid;
    tok_type_t         word_type;
    out_item_t         tok_str, tok_word, tok_par;
    logic [1:0]        cnt;

    always_comb
    begin
        byte_ovf = line_pos_reg >= PW'(MAX_LINE);
        ovf      = ovf_seen_reg | byte_ovf;
        is_quote = item.char_byte == CH_QUOTE;
        is_lp    = item.char_byte == CH_LPAREN;
        is_rp    = item.char_byte == CH_RPAREN;
        is_sep   = is_lp | is_rp | (item.char_byte == CH_SPACE);

        do_close = !byte_ovf & is_quote & quote_open_reg;
        do_open  = !byte_ovf & is_quote & !quote_open_reg;
        do_body  = !byte_ovf & !is_quote & quote_open_reg;
        do_sep   = !byte_ovf & !is_quote & !quote_open_reg & is_sep;
        do_word  = !byte_ovf & !is_quote & !quote_open_reg & !is_sep;

        q_mid  = (quote_open_reg | do_open) & !do_close;
        ws_mid = word_start_reg;
        wl_mid = word_len_reg;
        fl_mid = kw_flags_reg;
        bs_mid = body_start_reg;
        bl_mid = body_len_reg;

        if (do_close)
        begin
            ws_mid = '0;
            wl_mid = '0;
            fl_mid = KW_ALL;
            bs_mid = '0;
            bl_mid = '0;
        end
        if (do_open)
        begin
            bs_mid = 8'(line_pos_reg + PW'(1));
            bl_mid = '0;
        end
        if (do_body)
        begin
            bl_mid = body_len_reg + PW'(1);
        end
        if (do_word)
        begin
            if (word_len_reg == '0)
            begin
                ws_mid = 8'(line_pos_reg);
            end
            for (int k = 0; k < NUM_KW; k++)
            begin
                if (word_len_reg >= PW'(KW_LEN[k]) ||
                    KW_TEXT[k][word_len_reg[2:0]] != item.char_byte)
                begin
                    fl_mid[k] = 1'b0;
                end
            end
            wl_mid = word_len_reg + PW'(1);
        end

        flush    = do_sep | (item.line_end & !q_mid);
        word_tok = flush & (wl_mid != '0);
        par_tok  = do_sep & (is_lp | is_rp);

        priority if (fl_mid[0] && wl_mid == PW'(KW_LEN[0]))
            word_type = TOK_INCLUDE;
        else if (fl_mid[1] && wl_mid == PW'(KW_LEN[1]))
            word_type = TOK_FN;
        else if (fl_mid[2] && wl_mid == PW'(KW_LEN[2]))
            word_type = TOK_END;
        else
            word_type = TOK_ID;

        tok_str             = '0;
        tok_str.token_type  = TOK_STRING;
        tok_str.text_start  = (word_len_reg != '0) ? word_start_reg : 8'd0;
        tok_str.text_length = 9'(word_len_reg);
        tok_str.body_start  = body_start_reg;
        tok_str.body_length = 9'(body_len_reg);
        tok_str.overflow    = ovf;

        tok_word            = '0;
        tok_word.token_type = word_type;
        tok_word.overflow   = ovf;
        if (word_type == TOK_ID)
        begin
            tok_word.text_start  = ws_mid;
            tok_word.text_length = 9'(wl_mid);
        end

        tok_par            = '0;
        tok_par.token_type = is_lp ? TOK_LPAREN : TOK_RPAREN;
        tok_par.overflow   = ovf;

        cnt = {1'b0, do_close} + {1'b0, word_tok} + {1'b0, par_tok};

        res.count  = step ? cnt : 2'd0;
        res.first  = do_close ? tok_str : (word_tok ? tok_word : tok_par);
        res.second = tok_par;
        res.first.last_in_run  = cnt == 2'd1;
        res.second.last_in_run = 1'b1;

        quote_open_next = quote_open_reg;
        line_pos_next   = line_pos_reg;
        word_start_next = word_start_reg;
        word_len_next   = word_len_reg;
        body_start_next = body_start_reg;
        body_len_next   = body_len_reg;
        kw_flags_next   = kw_flags_reg;
        ovf_seen_next   = ovf_seen_reg;

        if (step)
        begin
            if (item.line_end)
            begin
                quote_open_next = 1'b0;
                line_pos_next   = '0;
                word_start_next = '0;
                word_len_next   = '0;
                body_start_next = '0;
                body_len_next   = '0;
                kw_flags_next   = KW_ALL;
                ovf_seen_next   = 1'b0;
            end
            else if (byte_ovf)
            begin
                ovf_seen_next = 1'b1;
            end
            else
            begin
                quote_open_next = q_mid;
                line_pos_next   = line_pos_reg + PW'(1);
                word_start_next = flush ? 8'd0 : ws_mid;
                word_len_next   = flush ? '0 : wl_mid;
                kw_flags_next   = flush ? KW_ALL : fl_mid;
                body_start_next = bs_mid;
                body_len_next   = bl_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_open_reg <= 1'b0;
            line_pos_reg   <= '0;
            word_start_reg <= '0;
            word_len_reg   <= '0;
            body_start_reg <= '0;
            body_len_reg   <= '0;
            kw_flags_reg   <= KW_ALL;
            ovf_seen_reg   <= 1'b0;
        end
        else
        begin
            quote_open_reg <= quote_open_next;
            line_pos_reg   <= line_pos_next;
            word_start_reg <= word_start_next;
            word_len_reg   <= word_len_next;
            body_start_reg <= body_start_next;
            body_len_reg   <= body_len_next;
            kw_flags_reg   <= kw_flags_next;
            ovf_seen_reg   <= ovf_seen_next;
        end
    end

endmodule

// File: rtl/core/kts_fifo.sv
// Token queue: takes up to two tokens a cycle, hands out one a cycle unless stalled.
// Depends on kts_pkg.
`timescale 1ns / 1ps

module kts_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kts_pkg::res_bundle_t push,
    output logic                 room,
    output logic                 valid,
    input  logic                 stall,
    output kts_pkg::out_item_t   head
);
    import kts_pkg::*;

    out_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;

    always_comb
    begin
        valid       = count_reg != '0;
        room        = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
        head        = mem[rd_ptr_reg];
        pop         = valid & !stall;
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        count_next  = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/keyword_token_scanner_core.sv
// Keyword token scanner: one byte per cycle in, tokens out via a 4-entry queue.
// Path: an accepted byte is held in the input register, decoded, and its tokens written to the queue.
// Throughput: one byte per cycle while the token queue holds two or fewer tokens;
// bytes giving two tokens are bounded by the one-token-per-cycle output.
// Reset: asynchronous, active low; clears line state, input valid flag and queue pointers and count.
// Depends on kts_pkg, kts_lexer, kts_fifo.
`timescale 1ns / 1ps

module keyword_token_scanner_core #(
    parameter int unsigned MAX_LINE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  kts_pkg::in_item_t  char_item,
    output logic               token_valid,
    input  logic               token_stall,
    output kts_pkg::out_item_t token_item
);
    import kts_pkg::*;

    logic        char_valid_reg, char_valid_next;
    in_item_t    char_item_reg;
    logic        room;
    logic        step;
    res_bundle_t res;

    always_comb
    begin
        step            = char_valid_reg & room;
        char_stall      = char_valid_reg & !room;
        char_valid_next = char_stall ? char_valid_reg : char_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_item_reg <= char_item;
        end
    end

    kts_lexer #(
        .MAX_LINE (MAX_LINE)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (char_item_reg),
        .res   (res)
    );

    kts_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res),
        .room  (room),
        .valid (token_valid),
        .stall (token_stall),
        .head  (token_item)
    );

endmodule

// File: rtl/core/kts_checker.sv
// Port-level checks for keyword_token_scanner_core, bound to the top level.
// Depends on kts_pkg and keyword_token_scanner_core_assert.svh.
`timescale 1ns / 1ps
`include "keyword_token_scanner_core_assert.svh"

module kts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               char_valid,
    input logic               char_stall,
    input kts_pkg::in_item_t  char_item,
    input logic               token_valid,
    input logic               token_stall,
    input kts_pkg::out_item_t token_item
);
    import kts_pkg::*;

    logic plain_tok;
    logic plain_empty;
    logic id_tok;
    logic no_body;

    assign plain_tok   = token_valid &&
                         (token_item.token_type == TOK_LPAREN ||
                          token_item.token_type == TOK_RPAREN ||
                          token_item.token_type == TOK_INCLUDE ||
                          token_item.token_type == TOK_FN ||
                          token_item.token_type == TOK_END);
    assign no_body     = token_item.body_length == 9'd0 && token_item.body_start == 8'd0;
    assign plain_empty = token_item.text_length == 9'd0 && token_item.text_start == 8'd0 &&
                         no_body;
    assign id_tok      = token_valid && token_item.token_type == TOK_ID;

    `KTS_ASSERT_NXT(a_char_hold, char_valid && char_stall, char_valid && $stable(char_item))
    `KTS_ASSERT_NXT(a_tok_hold, token_valid && token_stall, token_valid)
    `KTS_ASSERT_NXT(a_tok_stable, token_valid && token_stall, $stable(token_item))
    `KTS_ASSERT_IMP(a_plain_tok_empty, plain_tok, plain_empty)
    `KTS_ASSERT_IMP(a_id_no_body, id_tok, no_body)

endmodule

bind keyword_token_scanner_core kts_checker u_kts_checker (.*);

// File: sim/tb_keyword_token_scanner_core.sv
// Testbench for keyword_token_scanner_core: random and directed lines of bytes,
// with tokens predicted in-bench and checked in order as they come out.
// Depends on kts_pkg and the keyword_token_scanner_core RTL.
`timescale 1ns / 1ps

module tb_keyword_token_scanner_core;
    import kts_pkg::*;

    localparam int LINE_LIMIT   = 256;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 420;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    in_item_t   char_item;
    logic       token_valid;
    logic       token_stall;
    out_item_t  token_item;

    keyword_token_scanner_core #(
        .MAX_LINE(LINE_LIMIT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .char_item(char_item),
        .token_valid(token_valid),
        .token_stall(token_stall),
        .token_item(token_item)
    );

    // scanner state as the bench tracks it
    logic       in_string;
    int         col;
    int         word_pos;
    int         word_len;
    int         body_pos;
    int         body_len;
    logic [2:0] kw_live;
    logic       line_ovf;

    string     kw_word [3] = '{"include", "fn", "end"};
    tok_type_t kw_code [3] = '{TOK_INCLUDE, TOK_FN, TOK_END};
    string     word_pool [12] = '{"include", "fn", "end", "inc", "includes", "f",
                                  "fnn", "en", "endx", "e", "includ", "xfn"};

    out_item_t  pending_tokens [$];
    out_item_t  step_tokens [$];
    logic [7:0] line_buf [$];

    int   err_count   = 0;
    int   cycle_count = 0;
    int   bytes_sent  = 0;
    logic src_idle    = 1'b0;
    logic sink_idle   = 1'b0;
    logic hold_req    = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic out_item_t make_tok(tok_type_t kind, int ts, int tl, int bs, int bl);
        out_item_t t;
        t.token_type  = kind;
        t.text_start  = ts[7:0];
        t.text_length = tl[8:0];
        t.body_start  = bs[7:0];
        t.body_length = bl[8:0];
        t.overflow    = line_ovf;
        t.last_in_run = 1'b0;
        return t;
    endfunction

    function automatic void add_step_token(out_item_t t);
        step_tokens = {step_tokens, t};
    endfunction

    function automatic void add_line_byte(logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    function automatic void clear_word();
        word_len = 0;
        word_pos = 0;
        kw_live  = 3'b111;
    endfunction

    function automatic void reset_line();
        in_string = 1'b0;
        col       = 0;
        body_pos  = 0;
        body_len  = 0;
        line_ovf  = 1'b0;
        clear_word();
    endfunction

    function automatic void end_word();
        tok_type_t kind;
        kind = TOK_ID;
        if (word_len > 0) begin
            for (int i = 2; i >= 0; i--)
                if (kw_live[i] && word_len == kw_word[i].len())
                    kind = kw_code[i];
            if (kind == TOK_ID)
                add_step_token(make_tok(TOK_ID, word_pos, word_len, 0, 0));
            else
                add_step_token(make_tok(kind, 0, 0, 0, 0));
        end
        clear_word();
    endfunction

    // tokens caused by one accepted byte, appended to pending_tokens
    function automatic void lex_byte(logic [7:0] c, logic le);
        int p;
        step_tokens.delete();
        if (col >= LINE_LIMIT) begin
            line_ovf = 1'b1;
        end else begin
            p   = col;
            col = col + 1;
            if (c == CH_QUOTE && in_string) begin
                add_step_token(make_tok(TOK_STRING, (word_len != 0) ? word_pos : 0,
                                        word_len, body_pos, body_len));
                in_string = 1'b0;
                body_pos  = 0;
                body_len  = 0;
                clear_word();
            end else if (c == CH_QUOTE) begin
                in_string = 1'b1;
                body_pos  = p + 1;
                body_len  = 0;
            end else if (in_string) begin
                if (body_len < LINE_LIMIT)
                    body_len++;
            end else if (c == CH_SPACE || c == CH_LPAREN || c == CH_RPAREN) begin
                end_word();
                if (c == CH_LPAREN)
                    add_step_token(make_tok(TOK_LPAREN, 0, 0, 0, 0));
                else if (c == CH_RPAREN)
                    add_step_token(make_tok(TOK_RPAREN, 0, 0, 0, 0));
            end else begin
                if (word_len == 0)
                    word_pos = p;
                for (int i = 0; i < 3; i++)
                    if (word_len >= kw_word[i].len() || kw_word[i][word_len] != c)
                        kw_live[i] = 1'b0;
                if (word_len < LINE_LIMIT)
                    word_len++;
            end
        end
        if (le) begin
            if (!in_string)
                end_word();
            reset_line();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_in_run = 1'b1;
        pending_tokens = {pending_tokens, step_tokens};
    endfunction

    task automatic send_char(input logic [7:0] b, input logic le);
        int gap;
        in_item_t it;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.char_byte = b;
        it.line_end  = le;
        char_valid <= 1'b1;
        char_item  <= it;
        do
            @(posedge clk);
        while (char_stall);
        lex_byte(b, le);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic close_line);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], close_line && (i == s.len() - 1));
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_line_byte(s[i]);
    endfunction

    // mostly well-formed lines: keywords, near-keywords, names, parens, strings
    function automatic void build_line();
        int target;
        int n;
        logic [7:0] b;
        line_buf.delete();
        target = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 16);
        while (line_buf.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_text(word_pool[$urandom_range(0, 11)]);
                3: begin
                    n = $urandom_range(1, 6);
                    repeat (n) add_line_byte(8'($urandom_range(8'h61, 8'h7a)));
                end
                4, 5: begin
                    case ($urandom_range(0, 2))
                        0: add_line_byte(CH_SPACE);
                        1: add_line_byte(CH_LPAREN);
                        default: add_line_byte(CH_RPAREN);
                    endcase
                end
                6: begin
                    n = $urandom_range(0, 3);
                    repeat (n) add_line_byte(8'($urandom_range(8'h61, 8'h7a)));
                    add_line_byte(CH_QUOTE);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE);
                        if ($urandom_range(0, 1) == 0)
                            b = ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_LPAREN;
                        add_line_byte(b);
                    end
                    if ($urandom_range(0, 7) != 0)
                        add_line_byte(CH_QUOTE);
                end
                7: add_line_byte(8'($urandom_range(0, 255)));
                default: add_line_byte(CH_SPACE);
            endcase
        end
    endfunction

    function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk) begin : check_tokens
        out_item_t want;
        if (rst_n && token_valid && !token_stall) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token: expected none, got type %0d",
                         $time, token_item.token_type);
                err_count++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_type", want.token_type, token_item.token_type);
                check_field("text_start", want.text_start, token_item.text_start);
                check_field("text_length", want.text_length, token_item.text_length);
                check_field("body_start", want.body_start, token_item.body_start);
                check_field("body_length", want.body_length, token_item.body_length);
                check_field("overflow", want.overflow, token_item.overflow);
                check_field("last_in_run", want.last_in_run, token_item.last_in_run);
            end
        end
    end

    initial begin : sink_ctl
        int run_left;
        int hold_left;
        logic stall_next;
        token_stall = 1'b0;
        run_left    = 0;
        hold_left   = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                hold_left  = LONG_HOLD - 1;
                stall_next = 1'b1;
            end else if (!sink_idle) begin
                stall_next = 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                stall_next = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                run_left   = pick_gap();
                stall_next = 1'b1;
            end else begin
                stall_next = 1'b0;
            end
            token_stall <= stall_next;
        end
    end

    task automatic test_keywords_parens();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_text("fn(x)", 1'b1);
        send_text("include end", 1'b1);
    endtask

    task automatic test_strings();
        send_text("p\"a b\"", 1'b1);
        send_text("\"\"", 1'b1);
        send_text("\"x", 1'b1);
    endtask

    task automatic test_raw_bytes();
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b1);
    endtask

    // full-length word, then bytes past the limit
    task automatic test_long_line();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (LINE_LIMIT) send_char("a", 1'b0);
        send_char(CH_LPAREN, 1'b0);
        send_char(CH_RPAREN, 1'b1);
    endtask

    // receiver holds off while two-token bytes keep coming
    task automatic test_token_backlog();
        src_idle = 1'b0;
        hold_req = 1'b1;
        send_text("ab(cd)(e)(fn)(end)(x)", 1'b0);
        send_text("ab(cd)(e)(fn)(end)(x)", 1'b0);
        send_text("ab(cd)(e)(fn)(end)(x)", 1'b1);
    endtask

    task automatic test_random_lines();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        while (bytes_sent < stop_at) begin
            if (bytes_sent > stop_at - RANDOM_BYTES + 100 && $urandom_range(0, 7) == 0) begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            build_line();
            foreach (line_buf[i])
                send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    task automatic finish_run();
        char_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    endtask

    initial begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_item  = '0;
        reset_line();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_keywords_parens();
        test_strings();
        test_raw_bytes();
        test_long_line();
        test_token_backlog();
        test_random_lines();
        finish_run();
    end

endmodule
